FILE: hdl/isfp_pkg.sv
// shared types and constants for the imu serial frame parser
package isfp_pkg;

    // frame layout
    localparam int          FRAME_BYTES      = 11;
    localparam int          FRAMES_PER_GROUP = 4;
    localparam int          POS_W            = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_SYNC    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAY_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_PAY_HI  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_CSUM    = POS_W'(FRAME_BYTES - 1);
    localparam int          PAY_STORED       = 6;

    // byte codes
    localparam logic [7:0]  SYNC_BYTE   = 8'h55;
    localparam logic [7:0]  TYPE_FIRST  = 8'h51;
    localparam logic [7:0]  TYPE_LAST   = 8'h54;

    // status codes
    localparam logic [2:0]  ST_OK   = 3'd0;
    localparam logic [2:0]  ST_CSUM = 3'd1;
    localparam logic [2:0]  ST_TYPE = 3'd2;
    localparam logic [2:0]  ST_SYNC = 3'd3;
    localparam logic [2:0]  ST_DUP  = 3'd4;

    // result queue
    localparam int          QUEUE_DEPTH = 2;

    // one result item
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] value_x;
        logic signed [15:0] value_y;
        logic signed [15:0] value_z;
        logic [2:0]         status;
    } t_result;

    // queue status toward the input handshake and the back part
    typedef struct packed {
        logic full;
        logic valid;
    } t_queue_stat;

endpackage

FILE: hdl/isfp_front.sv
// front part: byte tracking, checksum accumulation and frame classification
module isfp_front
    import isfp_pkg::*;
#(
    parameter int P_FRAMES_PER_GROUP = FRAMES_PER_GROUP
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_rx_byte,
    input  logic       i_group_start,
    output logic       o_push,
    output t_result    o_result
);

    localparam int FRM_W = $clog2(P_FRAMES_PER_GROUP + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [FRM_W-1:0] r_frm, n_frm;
    logic             r_abandon, n_abandon;
    logic [3:0]       r_seen, n_seen;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_pay [PAY_STORED];

    logic [POS_W-1:0] pos_e;
    logic [FRM_W-1:0] frm_inc;
    logic [1:0]       kind_k;
    logic             pay_we;
    logic [2:0]       pay_idx;
    logic             push;
    t_result          res;

    // group start clears the per-group state before the byte is parsed
    always_comb begin
        pos_e     = i_group_start ? '0 : r_pos;
        n_pos     = pos_e;
        n_frm     = i_group_start ? '0 : r_frm;
        n_abandon = i_group_start ? 1'b0 : r_abandon;
        n_seen    = i_group_start ? '0 : r_seen;
        n_sum     = i_group_start ? '0 : r_sum;
        n_type    = r_type;
        frm_inc   = n_frm + FRM_W'(1);
        kind_k    = 2'(r_type - TYPE_FIRST);
        pay_we    = 1'b0;
        pay_idx   = 3'(pos_e - POS_PAY_LO);
        push      = 1'b0;
        res       = '0;
        if (!n_abandon) begin
            if (pos_e >= POS_CSUM) begin
                // end of frame
                push = 1'b1;
                if (r_type < TYPE_FIRST || r_type > TYPE_LAST) begin
                    res.status = ST_TYPE;
                end else begin
                    res.kind = kind_k;
                    if (n_seen[kind_k]) begin
                        res.status = ST_DUP;
                    end else begin
                        n_seen[kind_k] = 1'b1;
                        if (n_sum == i_rx_byte) begin
                            res.status  = ST_OK;
                            res.value_x = {r_pay[1], r_pay[0]};
                            res.value_y = {r_pay[3], r_pay[2]};
                            res.value_z = {r_pay[5], r_pay[4]};
                        end else begin
                            res.status = ST_CSUM;
                        end
                    end
                end
                n_pos = '0;
                n_sum = '0;
                n_frm = frm_inc;
                if (frm_inc >= FRM_W'(P_FRAMES_PER_GROUP)) begin
                    n_abandon = 1'b1;
                end
            end else if (pos_e == POS_SYNC && i_rx_byte != SYNC_BYTE) begin
                // bad sync drops the rest of the group
                push       = 1'b1;
                res.status = ST_SYNC;
                n_abandon  = 1'b1;
            end else begin
                if (pos_e == POS_TYPE) begin
                    n_type = i_rx_byte;
                end else if (pos_e >= POS_PAY_LO && pos_e <= POS_PAY_HI) begin
                    pay_we = 1'b1;
                end
                n_sum = r_sum + i_rx_byte;
                if (i_group_start) begin
                    n_sum = i_rx_byte;
                end
                n_pos = pos_e + POS_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_frm     <= '0;
            r_abandon <= 1'b0;
            r_seen    <= '0;
            r_sum     <= '0;
            r_type    <= '0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_frm     <= n_frm;
            r_abandon <= n_abandon;
            r_seen    <= n_seen;
            r_sum     <= n_sum;
            r_type    <= n_type;
        end
    end

    // sample bytes
    always_ff @(posedge i_clk) begin
        if (i_fire && pay_we) begin
            r_pay[pay_idx] <= i_rx_byte;
        end
    end

    assign o_push   = i_fire && push;
    assign o_result = res;

endmodule

FILE: hdl/isfp_queue.sv
// short result queue between the front and back parts
module isfp_queue
    import isfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_result,
    input  logic        i_pop,
    output t_result     o_result,
    output t_queue_stat o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_result          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    assign o_result     = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.valid = (r_count != '0);

endmodule

FILE: hdl/isfp_back.sv
// back part: output register that presents result items to the receiver
module isfp_back
    import isfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_stat i_stat,
    input  t_result     i_result,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output t_result     o_result
);

    logic    r_valid;
    t_result r_out;
    logic    load;

    // refill whenever the register is empty or being taken
    assign load  = i_stat.valid && (!r_valid || i_ready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

FILE: hdl/imu_serial_frame_parser_core.sv
// top level of the imu serial frame parser
//
// Input channel: one serial byte per item (i_rx_byte) with i_group_start
// marking the first byte of a group of frames; valid/ready handshake.
// Output channel: one result item per frame end or bad sync byte, giving
// kind, three raw signed 16-bit samples and a status; valid/ready.
// Throughput: one byte per cycle while o_ready is high. Bytes that neither
// end a frame nor break sync give no item.
// The queue is written at the edge that accepts the byte ending a frame;
// the back part then loads the output register, which drives o_valid,
// as soon as that register is empty or being taken.
// Stall: the two-entry queue plus the output register absorb results
// while i_ready is low; o_ready drops only when the queue is full.
// Reset: synchronous, active low; clears the frame counters, checksum,
// seen-kind flags, the queue and the output valid. Bytes arriving after
// reset without a group start are parsed as the start of a group.
module imu_serial_frame_parser_core
    import isfp_pkg::*;
#(
    parameter int P_FRAMES_PER_GROUP = FRAMES_PER_GROUP
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_group_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_value_x,
    output logic signed [15:0] o_value_y,
    output logic signed [15:0] o_value_z,
    output logic [2:0]         o_status
);

    t_queue_stat q_stat;
    t_result     front_res;
    t_result     q_res;
    t_result     out_res;
    logic        fire;
    logic        push;
    logic        pop;

    assign o_ready = !q_stat.full;
    assign fire    = i_valid && o_ready;

    // front part
    isfp_front #(
        .P_FRAMES_PER_GROUP (P_FRAMES_PER_GROUP)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_rx_byte     (i_rx_byte),
        .i_group_start (i_group_start),
        .o_push        (push),
        .o_result      (front_res)
    );

    // queue between the parts
    isfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_res),
        .i_pop    (pop),
        .o_result (q_res),
        .o_stat   (q_stat)
    );

    // back part
    isfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (q_stat),
        .i_result (q_res),
        .o_pop    (pop),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (out_res)
    );

    assign o_kind    = out_res.kind;
    assign o_value_x = out_res.value_x;
    assign o_value_y = out_res.value_y;
    assign o_value_z = out_res.value_z;
    assign o_status  = out_res.status;

endmodule

FILE: dv/imu_serial_frame_parser_core_test.sv
// self-checking testbench for the imu serial frame parser core
`timescale 1ns / 100ps

module imu_serial_frame_parser_core_test;
    import isfp_pkg::*;

    localparam int GROUP_FRAMES = FRAMES_PER_GROUP;
    localparam int RANDOM_BYTES = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;

    // frame kinds as reported on o_kind
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;
    localparam logic [1:0] KIND_MAG   = 2'd3;

    // type bytes just outside the known range
    localparam logic [7:0] TYPE_BELOW = TYPE_FIRST - 8'd1;
    localparam logic [7:0] TYPE_ABOVE = TYPE_LAST + 8'd1;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic [7:0]         i_rx_byte     = '0;
    logic               i_group_start = 1'b0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [1:0]         o_kind;
    logic signed [15:0] o_value_x;
    logic signed [15:0] o_value_y;
    logic signed [15:0] o_value_z;
    logic [2:0]         o_status;

    imu_serial_frame_parser_core #(
        .P_FRAMES_PER_GROUP(GROUP_FRAMES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .i_group_start(i_group_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_value_x    (o_value_x),
        .o_value_y    (o_value_y),
        .o_value_z    (o_value_z),
        .o_status     (o_status)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // parser state mirrored by the predictor
    logic [POS_W-1:0] byte_pos   = '0;
    int               frame_pos  = 0;
    logic             abandoned  = 1'b0;
    logic [3:0]       kinds_seen = '0;
    logic [7:0]       frame_sum  = '0;
    logic [7:0]       type_code  = '0;
    logic [7:0]       sample_bytes [PAY_STORED];

    t_result pending_results [$];

    int  error_count   = 0;
    int  sent_count    = 0;
    int  parsed_count  = 0;
    int  ignored_count = 0;
    int  checked_count = 0;
    int  status_hits [8];
    int  cycle_count   = 0;
    logic tx_fast = 1'b0;
    logic rx_fast = 1'b0;

    // expected result for one accepted byte, if it ends a frame or breaks sync
    task automatic predict_frame_result(input logic [7:0] b, input logic gs);
        t_result    r;
        logic [7:0] diff;
        logic [1:0] k;
        if (gs) begin
            byte_pos   = '0;
            frame_pos  = 0;
            abandoned  = 1'b0;
            kinds_seen = '0;
            frame_sum  = '0;
        end
        if (abandoned) begin
            ignored_count++;
        end else begin
            parsed_count++;
            r = '0;
            if (byte_pos >= POS_CSUM) begin
                // checksum byte closes the frame
                if (type_code < TYPE_FIRST || type_code > TYPE_LAST) begin
                    r.status = ST_TYPE;
                end else begin
                    diff   = type_code - TYPE_FIRST;
                    k      = diff[1:0];
                    r.kind = k;
                    if (kinds_seen[k]) begin
                        r.status = ST_DUP;
                    end else begin
                        kinds_seen[k] = 1'b1;
                        if (frame_sum == b) begin
                            r.status  = ST_OK;
                            r.value_x = {sample_bytes[1], sample_bytes[0]};
                            r.value_y = {sample_bytes[3], sample_bytes[2]};
                            r.value_z = {sample_bytes[5], sample_bytes[4]};
                        end else begin
                            r.status = ST_CSUM;
                        end
                    end
                end
                pending_results.push_back(r);
                byte_pos  = '0;
                frame_sum = '0;
                frame_pos++;
                if (frame_pos >= GROUP_FRAMES) abandoned = 1'b1;
            end else if (byte_pos == POS_SYNC && b != SYNC_BYTE) begin
                // lost sync: report and drop the rest of the group
                abandoned = 1'b1;
                r.status  = ST_SYNC;
                pending_results.push_back(r);
            end else begin
                if (byte_pos == POS_TYPE) begin
                    type_code = b;
                end else if (byte_pos >= POS_PAY_LO && byte_pos <= POS_PAY_HI) begin
                    sample_bytes[3'(byte_pos - POS_PAY_LO)] = b;
                end
                frame_sum = frame_sum + b;
                byte_pos  = byte_pos + 1'b1;
            end
        end
    endtask

    // watch accepted input items
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) predict_frame_result(i_rx_byte, i_group_start);
    end

    // compare each accepted result item with the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_kind, o_value_x, o_value_y, o_value_z, o_status};
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t unexpected result: kind %0d x %0d y %0d z %0d status %0d",
                         $time, got.kind, got.value_x, got.value_y, got.value_z,
                         got.status);
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                status_hits[want.status]++;
                if (got !== want) begin
                    error_count++;
                    $display("%0t mismatch: expected kind %0d x %0d y %0d z %0d status %0d",
                             $time, want.kind, want.value_x, want.value_y, want.value_z,
                             want.status);
                    $display("%0t            actual kind %0d x %0d y %0d z %0d status %0d",
                             $time, got.kind, got.value_x, got.value_y, got.value_z,
                             got.status);
                end
            end
        end
    end

    // receiver: random stall before each result item
    always begin : result_sink
        int stall;
        @(negedge i_clk);
        stall = rx_fast ? 0 : $urandom_range(0, 10);
        if (stall != 0) begin
            i_ready <= 1'b0;
            repeat (stall) @(negedge i_clk);
        end
        i_ready <= 1'b1;
        @(posedge i_clk);
        while (!o_valid) @(posedge i_clk);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("[imu_serial_frame_parser_core] ERROR");
            $finish;
        end
    end

    // send one byte item after a random gap
    task automatic send_byte(input logic [7:0] b, input logic gs);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_group_start <= gs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // send the first nbytes of a frame with the given samples
    task automatic send_frame(input logic [7:0] tcode, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z,
                              input logic good_sum, input logic opens_group,
                              input int nbytes);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] total;
        fb[0] = SYNC_BYTE;
        fb[1] = tcode;
        fb[2] = x[7:0];
        fb[3] = x[15:8];
        fb[4] = y[7:0];
        fb[5] = y[15:8];
        fb[6] = z[7:0];
        fb[7] = z[15:8];
        fb[8] = 8'($urandom);
        fb[9] = 8'($urandom);
        total = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++) total = total + fb[i];
        fb[FRAME_BYTES-1] = good_sum ? total : total ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < nbytes; i++) send_byte(fb[i], opens_group && (i == 0));
    endtask

    // hold the sender until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] type_of(input logic [1:0] kind);
        return TYPE_FIRST + 8'(kind);
    endfunction

    // sample value, biased toward the extremes
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // bytes after reset with no group start begin a group
    task automatic test_start_without_group_flag();
        send_frame(type_of(KIND_ACCEL), 16'h7fff, 16'h8000, 16'hffff, 1'b1, 1'b0,
                   FRAME_BYTES);
        send_frame(type_of(KIND_GYRO), 16'h0000, 16'h0001, 16'hfffe, 1'b1, 1'b0,
                   FRAME_BYTES);
    endtask

    // one good frame of each kind, then a byte past the complete group
    task automatic test_all_kinds();
        send_frame(type_of(KIND_ACCEL), 16'h8000, 16'h7fff, 16'h0000, 1'b1, 1'b1,
                   FRAME_BYTES);
        send_frame(type_of(KIND_GYRO), 16'hffff, 16'h8000, 16'h7fff, 1'b1, 1'b0,
                   FRAME_BYTES);
        send_frame(type_of(KIND_ANGLE), 16'h5555, 16'haaaa, 16'h00ff, 1'b1, 1'b0,
                   FRAME_BYTES);
        send_frame(type_of(KIND_MAG), 16'hff00, 16'h0000, 16'hffff, 1'b1, 1'b0,
                   FRAME_BYTES);
        send_byte(SYNC_BYTE, 1'b0);
    endtask

    // checksum failure, unknown types and duplicates
    task automatic test_frame_errors();
        send_frame(type_of(KIND_ACCEL), 16'h1234, 16'h5678, 16'h9abc, 1'b0, 1'b1,
                   FRAME_BYTES);
        send_frame(TYPE_BELOW, 16'h1111, 16'h2222, 16'h3333, 1'b1, 1'b0, FRAME_BYTES);
        send_frame(type_of(KIND_ACCEL), 16'h4444, 16'h5555, 16'h6666, 1'b1, 1'b0,
                   FRAME_BYTES);
        send_frame(TYPE_ABOVE, 16'h7777, 16'h8888, 16'h9999, 1'b0, 1'b0, FRAME_BYTES);
        // unknown type leaves the kind free for a later frame
        send_frame(8'hff, 16'h0102, 16'h0304, 16'h0506, 1'b1, 1'b1, FRAME_BYTES);
        send_frame(8'h00, 16'h0102, 16'h0304, 16'h0506, 1'b1, 1'b0, FRAME_BYTES);
        send_frame(type_of(KIND_MAG), 16'hfedc, 16'hba98, 16'h7654, 1'b1, 1'b0,
                   FRAME_BYTES);
    endtask

    // bad sync at the group start and after a good frame
    task automatic test_bad_sync();
        send_byte(8'h00, 1'b1);
        send_byte(SYNC_BYTE, 1'b0);
        send_byte(type_of(KIND_GYRO), 1'b0);
        send_frame(type_of(KIND_ANGLE), 16'h0000, 16'hffff, 16'h8000, 1'b1, 1'b1,
                   FRAME_BYTES);
        send_byte(8'hff, 1'b0);
        send_byte(8'haa, 1'b0);
    endtask

    // a group start in the middle of a frame restarts parsing
    task automatic test_restart_mid_frame();
        send_frame(type_of(KIND_GYRO), 16'h1357, 16'h2468, 16'h0f0f, 1'b1, 1'b1, 6);
        send_frame(type_of(KIND_GYRO), 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1,
                   FRAME_BYTES);
        drain_results();
    endtask

    // random groups, mostly well formed, some broken
    task automatic test_random_groups();
        int         target;
        int         group_no;
        int         order [4];
        int         swap_idx;
        int         tmp;
        int         pick;
        int         f;
        logic       done;
        logic       opens;
        logic [7:0] tcode;
        target   = parsed_count + RANDOM_BYTES;
        group_no = 0;
        while (parsed_count < target) begin
            if ($urandom_range(0, 7) == 0) tx_fast = ~tx_fast;
            if ($urandom_range(0, 7) == 0) rx_fast = ~rx_fast;
            if (group_no % 40 == 39) drain_results();
            group_no++;
            for (int i = 0; i < 4; i++) order[i] = i;
            for (int i = 3; i > 0; i--) begin
                swap_idx        = $urandom_range(0, i);
                tmp             = order[i];
                order[i]        = order[swap_idx];
                order[swap_idx] = tmp;
            end
            opens = ($urandom_range(0, 19) != 0);
            f     = 0;
            done  = 1'b0;
            while (f < GROUP_FRAMES && !done) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    // lost sync followed by junk
                    send_byte(SYNC_BYTE ^ 8'($urandom_range(1, 255)), opens && f == 0);
                    repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
                    done = 1'b1;
                end else if (pick < 8) begin
                    // frame cut short
                    send_frame(type_of(2'(order[f])), pick_sample(), pick_sample(),
                               pick_sample(), 1'b1, opens && f == 0,
                               $urandom_range(1, FRAME_BYTES - 1));
                    done = 1'b1;
                end else begin
                    if (pick < 75) tcode = type_of(2'(order[f]));
                    else if (pick < 88) tcode = type_of(2'($urandom_range(0, 3)));
                    else tcode = 8'($urandom);
                    send_frame(tcode, pick_sample(), pick_sample(), pick_sample(),
                               $urandom_range(0, 7) != 0, opens && f == 0, FRAME_BYTES);
                end
                f++;
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_start_without_group_flag();
        test_all_kinds();
        test_frame_errors();
        test_bad_sync();
        test_restart_mid_frame();
        test_random_groups();

        drain_results();
        repeat (16) @(posedge i_clk);
        $display("sent %0d bytes (%0d parsed, %0d ignored), checked %0d results",
                 sent_count, parsed_count, ignored_count, checked_count);
        $display("status ok %0d, checksum %0d, type %0d, sync %0d, duplicate %0d",
                 status_hits[ST_OK], status_hits[ST_CSUM], status_hits[ST_TYPE],
                 status_hits[ST_SYNC], status_hits[ST_DUP]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[imu_serial_frame_parser_core] OK");
        end else begin
            $display("%0d errors, %0d results never arrived", error_count,
                     pending_results.size());
            $display("[imu_serial_frame_parser_core] ERROR");
        end
        $finish;
    end

endmodule
